@@ src/wsdf_pkg.sv @@
// Shared constants and types for the WebSocket frame deframer.
package wsdf_pkg;

   // Seven-bit length codes that announce an extended length field.
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   // Extended length bytes still expected after the first one.
   localparam logic [2:0] EXT16_COUNT = 3'd1;
   localparam logic [2:0] EXT64_COUNT = 3'd7;

   // Result kinds.
   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   typedef struct packed {
      logic        kind;
      logic        fin;
      logic [3:0]  opcode;
      logic        masked;
      logic [63:0] payload_length;
      logic [7:0]  data_byte;
      logic        last;
   } result_type;

endpackage

@@ src/websocket_frame_deframer_top.sv @@
// WebSocket frame deframer: header parsing and payload unmasking, one byte per cycle.
//
// The request channel (req_valid, req_ready, req_in_byte) carries the received
// frame stream, one byte per transfer. The response channel (rsp_valid,
// rsp_ready and the rsp_ fields) carries at most one result per input byte:
// a header descriptor once the base header, any extended length and any
// masking key have been taken, then one unmasked payload byte for each
// payload byte, with rsp_last marking the final result of the frame. A frame
// with an empty payload ends at its descriptor.
// Each byte is decoded in the cycle of its transfer and its result appears in
// the output register in the following cycle; a new byte is taken every cycle
// while that register is empty or its result is taken. The rate is set by the
// single output register, which is refilled in the same cycle that its result is taken.
// When the receiver stalls with a result held, req_ready falls and the byte
// stream waits; header bytes that produce no result are still taken only
// while the output register can accept a result.
// Synchronous reset returns the parser to the first header byte of a frame
// and empties the output register.
module websocket_frame_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic        rsp_fin,
   output logic [3:0]  rsp_opcode,
   output logic        rsp_masked,
   output logic [63:0] rsp_payload_length,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last
);

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  ext_count_ff, ext_count_in;
   logic [63:0] length_ff, length_in;
   logic [31:0] key_ff, key_in;
   logic        masked_ff, masked_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic [63:0] left_ff, left_in;
   logic [1:0]  key_index_ff, key_index_in;

   logic                  rsp_valid_ff;
   wsdf_pkg::result_type  rsp_ff, rsp_in;
   logic                  produce;
   logic                  accept;
   logic [7:0]            key_byte;
   logic [6:0]            len_code;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign len_code  = req_in_byte[6:0];

   always_comb begin
      case (key_index_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      logic hdr_done;
      hdr_done     = 1'b0;
      phase_in     = phase_ff;
      ext_count_in = ext_count_ff;
      length_in    = length_ff;
      key_in       = key_ff;
      masked_in    = masked_ff;
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      left_in      = left_ff;
      key_index_in = key_index_ff;
      produce      = 1'b0;
      rsp_in       = rsp_ff;

      case (phase_ff)
         PH_HDR0: begin
            fin_in    = req_in_byte[7];
            opcode_in = req_in_byte[3:0];
            phase_in  = PH_HDR1;
         end
         PH_HDR1: begin
            masked_in    = req_in_byte[7];
            key_in       = '0;
            key_index_in = '0;
            if (len_code == wsdf_pkg::LEN_CODE_EXT16) begin
               length_in    = '0;
               ext_count_in = wsdf_pkg::EXT16_COUNT;
               phase_in     = PH_EXT;
            end else if (len_code == wsdf_pkg::LEN_CODE_EXT64) begin
               length_in    = '0;
               ext_count_in = wsdf_pkg::EXT64_COUNT;
               phase_in     = PH_EXT;
            end else begin
               length_in = {57'd0, len_code};
               if (req_in_byte[7]) begin
                  phase_in = PH_KEY;
               end else begin
                  hdr_done = 1'b1;
               end
            end
         end
         PH_EXT: begin
            length_in = {length_ff[55:0], req_in_byte};
            if (ext_count_ff != 3'd0) begin
               ext_count_in = ext_count_ff - 3'd1;
            end else if (masked_ff) begin
               phase_in = PH_KEY;
            end else begin
               hdr_done = 1'b1;
            end
         end
         PH_KEY: begin
            key_in       = {key_ff[23:0], req_in_byte};
            key_index_in = key_index_ff + 2'd1;
            // The fourth key byte wraps the count back to zero.
            if (key_index_ff == 2'd3) begin
               hdr_done = 1'b1;
            end
         end
         PH_DATA: begin
            key_index_in          = key_index_ff + 2'd1;
            left_in               = left_ff - 64'd1;
            produce               = 1'b1;
            rsp_in.kind           = wsdf_pkg::KIND_PAYLOAD;
            rsp_in.fin            = fin_ff;
            rsp_in.opcode         = opcode_ff;
            rsp_in.masked         = masked_ff;
            rsp_in.payload_length = '0;
            rsp_in.data_byte      = req_in_byte ^ key_byte;
            rsp_in.last           = (left_ff == 64'd1);
            if (left_ff == 64'd1) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            phase_in = PH_HDR0;
         end
      endcase

      if (hdr_done) begin
         produce               = 1'b1;
         rsp_in.kind           = wsdf_pkg::KIND_HEADER;
         rsp_in.fin            = fin_in;
         rsp_in.opcode         = opcode_in;
         rsp_in.masked         = masked_in;
         rsp_in.payload_length = length_in;
         rsp_in.data_byte      = '0;
         rsp_in.last           = (length_in == 64'd0);
         left_in               = length_in;
         key_index_in          = '0;
         phase_in              = (length_in == 64'd0) ? PH_HDR0 : PH_DATA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         ext_count_ff <= '0;
         length_ff    <= '0;
         key_ff       <= '0;
         masked_ff    <= 1'b0;
         fin_ff       <= 1'b0;
         opcode_ff    <= '0;
         left_ff      <= '0;
         key_index_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            ext_count_ff <= ext_count_in;
            length_ff    <= length_in;
            key_ff       <= key_in;
            masked_ff    <= masked_in;
            fin_ff       <= fin_in;
            opcode_ff    <= opcode_in;
            left_ff      <= left_in;
            key_index_ff <= key_index_in;
         end
         if (accept && produce) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // The result payload needs no reset; it is qualified by rsp_valid.
   always_ff @(posedge clock) begin
      if (accept && produce) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_fin            = rsp_ff.fin;
   assign rsp_opcode         = rsp_ff.opcode;
   assign rsp_masked         = rsp_ff.masked;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_data_byte      = rsp_ff.data_byte;
   assign rsp_last           = rsp_ff.last;

`ifndef SYNTHESIS
   // While payload is expected, at least one payload byte remains.
   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (left_ff != 64'd0))
      else $error("payload phase with no bytes left");

   // The final payload byte of a frame returns the parser to a new frame.
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_DATA && left_ff == 64'd1) |=> (phase_ff == PH_HDR0))
      else $error("frame did not end after its last payload byte");

   // A descriptor is last exactly when its frame has no payload.
   a_desc_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == wsdf_pkg::KIND_HEADER)
         |-> (rsp_ff.last == (rsp_ff.payload_length == 64'd0)
              && rsp_ff.data_byte == 8'd0))
      else $error("descriptor fields inconsistent");

   // Payload results carry no length.
   a_payload_len_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == wsdf_pkg::KIND_PAYLOAD)
         |-> (rsp_ff.payload_length == 64'd0))
      else $error("payload result with non-zero length");
`endif

endmodule
